/* rtl/core/mspfp_pkg.sv */
// Package for the MSP frame parser: result status codes, sync and direction
// characters, the result record and the CRC-8 DVB-S2 byte step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mspfp_pkg;

  // Framing characters
  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChM      = 8'h4D;  // 'M'
  localparam logic [7:0] ChE      = 8'h45;  // 'E'
  localparam logic [7:0] ChX      = 8'h58;  // 'X'
  localparam logic [7:0] ChLt     = 8'h3C;  // '<'
  localparam logic [7:0] ChGt     = 8'h3E;  // '>'

  // CRC-8 DVB-S2 polynomial
  localparam logic [7:0] CrcPoly = 8'hD5;

  // Reset value of the payload limit
  localparam logic [15:0] MaxPayloadReset = 16'd256;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_BUSY    = 3'd0,
    STAT_PAYLOAD = 3'd1,
    STAT_OK      = 3'd2,
    STAT_SYNC    = 3'd3,
    STAT_OVRSIZE = 3'd4,
    STAT_CHKBAD  = 3'd5
  } status_e;

  // One result item
  typedef struct packed {
    status_e     status;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] command;
    logic [15:0] payload_size;
    logic        version;
    logic        variant;
    logic        direction;
    logic [7:0]  frame_flags;
  } result_t;

  // One byte through CRC-8 DVB-S2, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/msp_frame_parser.sv */
// MSP V1/V2 frame parser: one received byte in, one result item out.
// Parse state update and result in one pass, with an output register and skid.
// Depends on mspfp_pkg.
// Each result is registered in the output register, or in the skid slot while one waits.
// Throughput: one byte per cycle while the skid slot is empty; the parse step
// (including the CRC-8 byte step) sits between the state registers and the output register.
// A two-slot output stage (register plus skid) keeps input ready while one
// result waits on the output.
// Reset: asynchronous, active low; parser idle, checksums and frame fields
// cleared, payload limit 256, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module msp_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: max_payload
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input items
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // result items
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] data_byte, [23:8] byte_index, [39:24] command, [55:40] payload_size,
  // [56] version, [57] variant, [58] direction, [66:59] frame_flags, [71:67] zero
  output logic [71:0]      m_axis_tdata_o,
  output logic [2:0]       m_axis_tuser_o    // [2:0] status
);
  import mspfp_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_START = 10'b00_0000_0010,
    ST_DIR1  = 10'b00_0000_0100,
    ST_DIR2  = 10'b00_0000_1000,
    ST_HDR1  = 10'b00_0001_0000,
    ST_HDR2  = 10'b00_0010_0000,
    ST_PAY1  = 10'b00_0100_0000,
    ST_PAY2  = 10'b00_1000_0000,
    ST_CHK1  = 10'b01_0000_0000,
    ST_CHK2  = 10'b10_0000_0000
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] max_payload_q;
  logic [15:0] byte_count_q, byte_count_d;
  logic [15:0] expected_len_q, expected_len_d;
  logic [7:0]  xor_sum_q, xor_sum_d;
  logic [7:0]  crc_sum_q, crc_sum_d;
  logic [7:0]  hdr_q [4];
  logic [7:0]  hdr_d [4];
  logic [15:0] command_q, command_d;
  logic [7:0]  flags_q, flags_d;
  logic [2:0]  kind_q, kind_d;   // bit 0 V2, bit 1 'E' variant, bit 2 reply

  result_t     res;
  result_t     out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_accept, out_take;
  logic [15:0] size_sel;
  logic [15:0] count_inc;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take        = out_valid_q && m_axis_tready_i;
  assign count_inc       = byte_count_q + 16'd1;

  // Parse step
  always_comb begin
    state_d        = state_q;
    byte_count_d   = byte_count_q;
    expected_len_d = expected_len_q;
    xor_sum_d      = xor_sum_q;
    crc_sum_d      = crc_sum_q;
    hdr_d          = hdr_q;
    command_d      = command_q;
    flags_d        = flags_q;
    kind_d         = kind_q;
    size_sel       = 16'd0;
    res.status     = STAT_BUSY;
    res.data_byte  = 8'd0;
    res.byte_index = 16'd0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tdata_i == ChDollar) state_d = ST_START;
      end
      ST_START: begin
        byte_count_d   = 16'd0;
        xor_sum_d      = 8'd0;
        crc_sum_d      = 8'd0;
        command_d      = 16'd0;
        expected_len_d = 16'd0;
        flags_d        = 8'd0;
        priority if (s_axis_tdata_i == ChM) begin
          kind_d  = {kind_q[2], 2'b00};
          state_d = ST_DIR1;
        end else if (s_axis_tdata_i == ChE) begin
          kind_d  = {kind_q[2], 2'b10};
          state_d = ST_DIR1;
        end else if (s_axis_tdata_i == ChX) begin
          kind_d  = {kind_q[2], 2'b01};
          state_d = ST_DIR2;
        end else begin
          res.status = STAT_SYNC;
          state_d    = ST_IDLE;
        end
      end
      ST_DIR1, ST_DIR2: begin
        if (s_axis_tdata_i == ChLt || s_axis_tdata_i == ChGt) begin
          kind_d  = {(s_axis_tdata_i == ChGt), kind_q[1:0]};
          state_d = (state_q == ST_DIR1) ? ST_HDR1 : ST_HDR2;
        end else begin
          res.status = STAT_SYNC;
          state_d    = ST_IDLE;
        end
      end
      ST_HDR1: begin
        xor_sum_d = xor_sum_q ^ s_axis_tdata_i;
        if (byte_count_q == 16'd0) begin
          hdr_d[0]     = s_axis_tdata_i;
          byte_count_d = 16'd1;
        end else begin
          command_d      = {8'd0, s_axis_tdata_i};
          size_sel       = {8'd0, hdr_q[0]};
          expected_len_d = size_sel;
          byte_count_d   = 16'd0;
          if (size_sel > max_payload_q) begin
            res.status = STAT_OVRSIZE;
            state_d    = ST_IDLE;
          end else begin
            state_d = (size_sel != 16'd0) ? ST_PAY1 : ST_CHK1;
          end
        end
      end
      ST_HDR2: begin
        crc_sum_d = crc8_step(crc_sum_q, s_axis_tdata_i);
        if (byte_count_q < 16'd4) begin
          hdr_d[byte_count_q[1:0]] = s_axis_tdata_i;
          byte_count_d             = count_inc;
        end else begin
          flags_d        = hdr_q[0];
          command_d      = {hdr_q[2], hdr_q[1]};
          size_sel       = {s_axis_tdata_i, hdr_q[3]};
          expected_len_d = size_sel;
          byte_count_d   = 16'd0;
          if (size_sel > max_payload_q) begin
            res.status = STAT_OVRSIZE;
            state_d    = ST_IDLE;
          end else begin
            state_d = (size_sel != 16'd0) ? ST_PAY2 : ST_CHK2;
          end
        end
      end
      ST_PAY1, ST_PAY2: begin
        if (state_q == ST_PAY1) xor_sum_d = xor_sum_q ^ s_axis_tdata_i;
        else crc_sum_d = crc8_step(crc_sum_q, s_axis_tdata_i);
        res.status     = STAT_PAYLOAD;
        res.data_byte  = s_axis_tdata_i;
        res.byte_index = byte_count_q;
        byte_count_d   = count_inc;
        if (count_inc == expected_len_q) begin
          state_d = (state_q == ST_PAY1) ? ST_CHK1 : ST_CHK2;
        end
      end
      ST_CHK1: begin
        res.status = (xor_sum_q == s_axis_tdata_i) ? STAT_OK : STAT_CHKBAD;
        state_d    = ST_IDLE;
      end
      ST_CHK2: begin
        res.status = (crc_sum_q == s_axis_tdata_i) ? STAT_OK : STAT_CHKBAD;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res.command      = command_d;
    res.payload_size = expected_len_d;
    res.version      = kind_d[0];
    res.variant      = kind_d[1];
    res.direction    = kind_d[2];
    res.frame_flags  = flags_d;
  end

  // Parser state, updated on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      byte_count_q   <= 16'd0;
      expected_len_q <= 16'd0;
      xor_sum_q      <= 8'd0;
      crc_sum_q      <= 8'd0;
      command_q      <= 16'd0;
      flags_q        <= 8'd0;
      kind_q         <= 3'd0;
    end else if (in_accept) begin
      state_q        <= state_d;
      byte_count_q   <= byte_count_d;
      expected_len_q <= expected_len_d;
      xor_sum_q      <= xor_sum_d;
      crc_sum_q      <= crc_sum_d;
      command_q      <= command_d;
      flags_q        <= flags_d;
      kind_q         <= kind_d;
    end
  end

  // Header byte store, always written before read within a frame
  always_ff @(posedge clk_i) begin
    if (in_accept) hdr_q <= hdr_d;
  end

  // Payload limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  // Output stage control: main register plus skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_accept) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {5'd0, out_q.frame_flags, out_q.direction, out_q.variant,
                            out_q.version, out_q.payload_size, out_q.command,
                            out_q.byte_index, out_q.data_byte};

  // Skid slot only ever fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full with output register empty");

  // Payload index always lies inside the declared payload
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STAT_PAYLOAD) |->
      (out_q.byte_index < out_q.payload_size))
    else $error("payload byte index beyond declared size");

  // Data and index are zero on every non-payload result
  a_non_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != STAT_PAYLOAD) |->
      (out_q.data_byte == 8'd0 && out_q.byte_index == 16'd0))
    else $error("non-payload result carries data");

  // The checksum byte always ends the frame
  a_chk_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (state_q == ST_CHK1 || state_q == ST_CHK2)) |=> (state_q == ST_IDLE))
    else $error("parser did not return to idle after checksum");

endmodule

`default_nettype wire
